### sv/shs_pkg.sv
// Shared types and constants for the SHA-256 stream hasher.
package shs_pkg;

    // Control sequence of the hasher.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_PADLEN,
        S_LOAD,
        S_ROUND,
        S_UPD,
        S_OUT_RD,
        S_OUT_WR
    } t_state;

    // Working variables a..h, element 0 is a.
    typedef logic [7:0][31:0] t_work;

    // Message schedule window, element 0 is the word used in the current round.
    typedef logic [15:0][31:0] t_win;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

endpackage

### sv/shs_round.sv
// One SHA-256 compression round together with the next message schedule word.
module shs_round (
    input  shs_pkg::t_work i_work,
    input  shs_pkg::t_win  i_win,
    input  logic [31:0]    i_k,
    output shs_pkg::t_work o_work,
    output logic [31:0]    o_w_next
);
    import shs_pkg::*;

    function automatic logic [31:0] f_rotr(input logic [31:0] v, input int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction

    logic [31:0] w_big1;
    logic [31:0] w_choose;
    logic [31:0] w_t1;
    logic [31:0] w_big0;
    logic [31:0] w_major;
    logic [31:0] w_t2;
    logic [31:0] w_sig0;
    logic [31:0] w_sig1;

    // Round function on the working variables.
    always_comb begin
        w_big1   = f_rotr(i_work[4], 6) ^ f_rotr(i_work[4], 11) ^ f_rotr(i_work[4], 25);
        w_choose = (i_work[4] & i_work[5]) ^ (~i_work[4] & i_work[6]);
        w_t1     = i_work[7] + w_big1 + w_choose + i_k + i_win[0];
        w_big0   = f_rotr(i_work[0], 2) ^ f_rotr(i_work[0], 13) ^ f_rotr(i_work[0], 22);
        w_major  = (i_work[0] & i_work[1]) ^ (i_work[0] & i_work[2]) ^ (i_work[1] & i_work[2]);
        w_t2     = w_big0 + w_major;
        o_work[0] = w_t1 + w_t2;
        o_work[1] = i_work[0];
        o_work[2] = i_work[1];
        o_work[3] = i_work[2];
        o_work[4] = i_work[3] + w_t1;
        o_work[5] = i_work[4];
        o_work[6] = i_work[5];
        o_work[7] = i_work[6];
    end

    // Schedule word W[t+16] for the current round t.
    always_comb begin
        w_sig0   = f_rotr(i_win[1], 7) ^ f_rotr(i_win[1], 18) ^ (i_win[1] >> 3);
        w_sig1   = f_rotr(i_win[14], 17) ^ f_rotr(i_win[14], 19) ^ (i_win[14] >> 10);
        o_w_next = i_win[0] + w_sig0 + i_win[9] + w_sig1;
    end

endmodule

### sv/sha256_stream_hasher_unit.sv
// Top level of the SHA-256 stream hasher: byte intake, padding, compression and digest output.
//
// The hasher takes one message byte per cycle while a 64-byte block is being
// collected. When a block is full the input stalls while the block is read
// from the 16-word message memory and the hash from the 8-word hash memory,
// the rounds run one at a time through a single round unit, and the result is
// added back into the hash memory.
// An end mark adds the padding bytes (9 to 72 bytes), a switch to the length
// bytes, one or two more compressions, and then eight digest words, word 0 first.
// No clearing pass is needed after reset; the hash returns to its initial
// value at once after each digest.
module sha256_stream_hasher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tuser,   // byte_present
    input  logic        i_s_axis_tlast,   // end_of_message
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // digest_word
    output logic [2:0]  o_m_axis_tuser,   // word_index
    output logic        o_m_axis_tlast    // last_word
);
    import shs_pkg::*;

    // Memories.
    logic [31:0] wmem [16];
    logic [31:0] hmem [8];

    t_state      r_state, n_state;
    t_state      r_resume, n_resume;
    logic [6:0]  r_cnt, n_cnt;
    logic [5:0]  r_fill;
    logic [23:0] r_word;
    logic [60:0] r_total, n_total;
    logic [63:0] r_bits, n_bits;
    t_win        r_win, n_win;
    t_work       r_work, n_work;
    logic [7:0]  r_hvalid;
    logic [31:0] r_wrd;
    logic [31:0] r_hrd;
    logic        r_hvq;
    logic [2:0]  r_hraq;
    logic [2:0]  r_oidx, n_oidx;
    logic        r_ov;
    logic [31:0] r_odata;
    logic [2:0]  r_otag;
    logic        r_olast;

    logic        in_acc;
    logic        push_en;
    logic [7:0]  push_byte;
    logic [3:0]  wmem_ra;
    logic [2:0]  hmem_ra;
    logic        hmem_we;
    logic [2:0]  hmem_wa;
    logic [31:0] hmem_wd;
    logic        out_ld;
    logic        finish;
    logic [31:0] hval;
    t_work       rnd_work;
    logic [31:0] rnd_wnext;

    // Bytes are taken only while no block or digest is being processed.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // Hash word read back: entries not yet written since the last digest hold the initial value.
    assign hval = r_hvq ? r_hrd : INIT_HASH[r_hraq];

    shs_round u_round (
        .i_work   (r_work),
        .i_win    (r_win),
        .i_k      (ROUND_K[r_cnt[5:0]]),
        .o_work   (rnd_work),
        .o_w_next (rnd_wnext)
    );

    // Next state and datapath control.
    always_comb begin
        n_state   = r_state;
        n_resume  = r_resume;
        n_cnt     = r_cnt;
        n_total   = r_total;
        n_bits    = r_bits;
        n_win     = r_win;
        n_work    = r_work;
        n_oidx    = r_oidx;
        push_en   = 1'b0;
        push_byte = 8'h00;
        wmem_ra   = r_cnt[3:0];
        hmem_ra   = r_cnt[2:0];
        hmem_we   = 1'b0;
        hmem_wa   = r_cnt[2:0] - 3'd1;
        hmem_wd   = hval + r_work[0];
        out_ld    = 1'b0;
        finish    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    push_en   = i_s_axis_tuser;
                    push_byte = i_s_axis_tdata;
                    if (i_s_axis_tuser) begin
                        n_total = r_total + 61'd1;
                    end
                    if (i_s_axis_tuser && r_fill == LAST_POS) begin
                        n_state  = S_LOAD;
                        n_cnt    = 7'd0;
                        n_resume = i_s_axis_tlast ? S_PAD80 : S_IDLE;
                    end else if (i_s_axis_tlast) begin
                        n_state = S_PAD80;
                    end
                end
            end
            S_PAD80: begin
                push_en   = 1'b1;
                push_byte = PAD_BYTE;
                n_bits    = {r_total, 3'b000};
                n_oidx    = 3'd0;
                n_state   = S_PADZ;
                if (r_fill == LAST_POS) begin
                    n_state  = S_LOAD;
                    n_cnt    = 7'd0;
                    n_resume = S_PADZ;
                end
            end
            S_PADZ: begin
                if (r_fill == LEN_POS) begin
                    n_state = S_PADLEN;
                end else begin
                    push_en = 1'b1;
                    if (r_fill == LAST_POS) begin
                        n_state  = S_LOAD;
                        n_cnt    = 7'd0;
                        n_resume = S_PADZ;
                    end
                end
            end
            S_PADLEN: begin
                push_en   = 1'b1;
                push_byte = r_bits[63:56];
                n_bits    = {r_bits[55:0], 8'h00};
                if (r_fill == LAST_POS) begin
                    n_state  = S_LOAD;
                    n_cnt    = 7'd0;
                    n_resume = S_OUT_RD;
                end
            end
            S_LOAD: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt != 7'd0) begin
                    n_win = {r_wrd, r_win[15:1]};
                end
                if (r_cnt != 7'd0 && r_cnt <= 7'd8) begin
                    n_work = {hval, r_work[7:1]};
                end
                if (r_cnt == 7'd16) begin
                    n_state = S_ROUND;
                    n_cnt   = 7'd0;
                end
            end
            S_ROUND: begin
                n_work = rnd_work;
                n_win  = {rnd_wnext, r_win[15:1]};
                n_cnt  = r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    n_state = S_UPD;
                    n_cnt   = 7'd0;
                end
            end
            S_UPD: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt != 7'd0) begin
                    hmem_we = 1'b1;
                    n_work  = {r_work[0], r_work[7:1]};
                end
                if (r_cnt == 7'd8) begin
                    n_state = r_resume;
                    n_cnt   = 7'd0;
                end
            end
            S_OUT_RD: begin
                hmem_ra = r_oidx;
                n_state = S_OUT_WR;
            end
            S_OUT_WR: begin
                hmem_ra = r_oidx;
                if (!r_ov || i_m_axis_tready) begin
                    out_ld = 1'b1;
                    if (r_oidx == 3'd7) begin
                        finish  = 1'b1;
                        n_total = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_oidx  = r_oidx + 3'd1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_resume <= S_IDLE;
            r_cnt    <= '0;
            r_fill   <= '0;
            r_total  <= '0;
            r_hvalid <= '0;
            r_oidx   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_resume <= n_resume;
            r_cnt    <= n_cnt;
            r_total  <= n_total;
            r_oidx   <= n_oidx;
            if (push_en) begin
                r_fill <= r_fill + 6'd1;
            end
            if (finish) begin
                r_hvalid <= '0;
            end else if (hmem_we) begin
                r_hvalid[hmem_wa] <= 1'b1;
            end
            if (out_ld) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_win  <= n_win;
        r_work <= n_work;
        if (push_en) begin
            r_word <= {r_word[15:0], push_byte};
        end
        if (out_ld) begin
            r_odata <= hval;
            r_otag  <= r_oidx;
            r_olast <= (r_oidx == 3'd7);
        end
    end

    // Message memory: a word is written once its fourth byte arrives.
    always_ff @(posedge i_clk) begin
        if (push_en && r_fill[1:0] == 2'd3) begin
            wmem[r_fill[5:2]] <= {r_word, push_byte};
        end
        r_wrd <= wmem[wmem_ra];
    end

    // Hash memory with its read address kept for the initial-value fallback.
    always_ff @(posedge i_clk) begin
        if (hmem_we) begin
            hmem[hmem_wa] <= hmem_wd;
        end
        r_hrd  <= hmem[hmem_ra];
        r_hvq  <= r_hvalid[hmem_ra];
        r_hraq <= hmem_ra;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_otag;
    assign o_m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    a_last_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser == 3'd7)
        else $error("last digest word carries a wrong index");

    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_s_axis_tuser && r_fill == LAST_POS |=> r_state == S_LOAD && r_fill == 6'd0)
        else $error("full block did not start a compression");

    a_finish_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_hvalid == 8'h00 && r_fill == 6'd0 && r_total == 61'd0)
        else $error("state not cleared after digest");

    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD || r_state == S_ROUND || r_state == S_UPD) |-> !push_en)
        else $error("byte written during compression");
`endif

endmodule

### tb/sv/tb_sha256_stream_hasher_unit.sv
// Self-checking testbench for the SHA-256 stream hasher with a class-based digest scoreboard.
`timescale 1ns / 100ps

// Models the hasher and holds the digest words still owed by the block.
class digest_scoreboard;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    t_digest_word pending_words[$];
    logic [31:0]  hash_state [8];
    logic [7:0]   block_bytes [64];
    int unsigned  fill;
    logic [60:0]  msg_bytes;
    int unsigned  mismatches;

    function new();
        mismatches = 0;
        restart();
    endfunction

    // Return to the state of a fresh message.
    function void restart();
        for (int i = 0; i < 8; i++) hash_state[i] = shs_pkg::INIT_HASH[i];
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
        fill = 0;
        msg_bytes = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] v, int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    // One SHA-256 compression of the held block into the running hash.
    function void compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + shs_pkg::ROUND_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    // Note one accepted input transfer and queue any digest it finishes.
    function void note_input(logic [7:0] data, logic present, logic eom);
        logic [63:0]  bit_len;
        int unsigned  pos;
        t_digest_word dw;
        if (present) begin
            block_bytes[fill] = data;
            msg_bytes = msg_bytes + 1'b1;
            fill++;
            if (fill == 64) begin
                compress();
                fill = 0;
            end
        end
        if (!eom) return;
        bit_len = {msg_bytes, 3'b000};
        pos = fill;
        block_bytes[pos] = shs_pkg::PAD_BYTE;
        pos++;
        // The length does not fit behind the pad byte: spend an extra block.
        if (pos > shs_pkg::LEN_POS) begin
            while (pos < 64) block_bytes[pos++] = 8'h00;
            compress();
            pos = 0;
        end
        while (pos < shs_pkg::LEN_POS) block_bytes[pos++] = 8'h00;
        for (int i = 0; i < 8; i++)
            block_bytes[shs_pkg::LEN_POS + i] = bit_len[63 - 8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++) begin
            dw.word  = hash_state[i];
            dw.index = i[2:0];
            dw.last  = (i == 7);
            pending_words.push_back(dw);
        end
        restart();
    endfunction

    // Compare one accepted output transfer with the oldest owed digest word.
    function void check_result(logic [31:0] word, logic [2:0] index, logic last);
        t_digest_word dw;
        if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected digest word %h index %0d last %b", word, index, last);
            return;
        end
        dw = pending_words.pop_front();
        if (word !== dw.word || index !== dw.index || last !== dw.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                         dw.word, dw.index, dw.last, word, index, last);
        end
    endfunction

endclass

module tb_sha256_stream_hasher_unit;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        s_user = 1'b0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [31:0] m_data;
    logic [2:0]  m_user;
    logic        m_last;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned item_count = 0;
    int unsigned quiet_cycles = 0;

    digest_scoreboard sb = new();

    sha256_stream_hasher_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // data_byte
        .i_s_axis_tuser  (s_user),   // byte_present
        .i_s_axis_tlast  (s_last),   // end_of_message
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // digest_word
        .o_m_axis_tuser  (m_user),   // word_index
        .o_m_axis_tlast  (m_last)    // last_word
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Random back-pressure on the digest side.
    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every output transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) sb.check_result(m_data, m_user, m_last);
    end

    // End the run when no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_sha256_stream_hasher_unit failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item and wait for its transfer.
    task automatic send_item(logic [7:0] data, logic present, logic eom);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= data;
        s_user  <= present;
        s_last  <= eom;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        sb.note_input(data, present, eom);
        item_count++;
    endtask

    // Send a message of random bytes, ending on the last byte or on a bare end mark.
    task automatic send_message(int unsigned len, bit bare_end, bit noise);
        for (int unsigned i = 0; i < len; i++) begin
            if (noise && $urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !bare_end);
        end
        if (len == 0 || bare_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Stop offering items and wait until every owed digest word has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, an ignored item, a three-byte message, byte extremes, bare end mark.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'ha5, 1'b0, 1'b1);

        // Hold off until the directed digests are all out.
        wait_drained();

        // Random messages; boundary lengths exercise the extra padding block.
        while (item_count < 170) begin
            if (item_count < 57) begin
                send_idle_pct = 27;
                recv_idle_pct = 82;
            end else if (item_count < 114) begin
                send_idle_pct = 82;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(0, 9))
                0: len = 55;
                1: len = 56;
                2: len = ($urandom_range(0, 1) == 0) ? 63 : 64;
                default: len = $urandom_range(0, 12);
            endcase
            // Keep the total number of items near the planned count.
            if (len > 170 - item_count) len = 170 - item_count;
            send_message(len, $urandom_range(0, 3) == 0, 1'b1);
        end
        s_valid <= 1'b0;

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
            $display("tb_sha256_stream_hasher_unit passed");
        end else begin
            $display("tb_sha256_stream_hasher_unit failed");
        end
        $finish;
    end

endmodule

### sha256_stream_hasher_unit.f
sv/shs_pkg.sv
sv/shs_round.sv
sv/sha256_stream_hasher_unit.sv
tb/sv/tb_sha256_stream_hasher_unit.sv
